[rtl/hxt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the hextile rectangle decoder.
// No dependencies; the top level, parser and result register refer to this package.
package hxt_pkg;

  // Tile edge length in pixels
  localparam int unsigned TileSize = 16;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned DimW     = 5;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned RegIdxW  = 2;
  localparam int unsigned RawCntW  = 9;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_SUBENC = 4'd0;
  localparam logic [PhaseW-1:0] PH_BG     = 4'd1;
  localparam logic [PhaseW-1:0] PH_FG     = 4'd2;
  localparam logic [PhaseW-1:0] PH_NSUB   = 4'd3;
  localparam logic [PhaseW-1:0] PH_SUBCOL = 4'd4;
  localparam logic [PhaseW-1:0] PH_SUBPOS = 4'd5;
  localparam logic [PhaseW-1:0] PH_SUBDIM = 4'd6;
  localparam logic [PhaseW-1:0] PH_RAW    = 4'd7;
  localparam logic [PhaseW-1:0] PH_DONE   = 4'd8;

  // Subencoding flag bits
  localparam int unsigned SE_RAW_BIT = 0;
  localparam int unsigned SE_BG_BIT  = 1;
  localparam int unsigned SE_FG_BIT  = 2;
  localparam int unsigned SE_ANY_BIT = 3;
  localparam int unsigned SE_COL_BIT = 4;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] REG_RECT_LEFT   = 2'd0;
  localparam logic [RegIdxW-1:0] REG_RECT_TOP    = 2'd1;
  localparam logic [RegIdxW-1:0] REG_RECT_WIDTH  = 2'd2;
  localparam logic [RegIdxW-1:0] REG_RECT_HEIGHT = 2'd3;

  typedef struct packed {
    logic               we;
    logic [RegIdxW-1:0] index;
    logic [CoordW-1:0]  wdata;
  } hxt_cfg_wr_t;

  typedef struct packed {
    logic              fill_valid;
    logic [CoordW-1:0] fill_x;
    logic [CoordW-1:0] fill_y;
    logic [DimW-1:0]   fill_w;
    logic [DimW-1:0]   fill_h;
    logic [ColorW-1:0] fill_color;
    logic              rect_done;
  } hxt_result_t;

  // Tile extent left over from offset, capped at one tile
  function automatic logic [DimW-1:0] clip_len(input logic [CoordW-1:0] total,
                                               input logic [CoordW-1:0] offset);
    logic [CoordW-1:0] rest;
    rest = total - offset;
    if (rest < CoordW'(TileSize)) begin
      clip_len = rest[DimW-1:0];
    end else begin
      clip_len = DimW'(TileSize);
    end
  endfunction

endpackage

[rtl/hextile_rect_decoder.sv]
`timescale 1ns / 1ps
// Hextile rectangle decoder, top level.
// Depends on hxt_pkg, hxt_in_stage, hxt_parser and hxt_out_stage.
//
// Usage:
//   Write rect_left/top/width/height through cfg_we_i/cfg_index_i/cfg_wdata_i
//   while the block is idle; any register write restarts at the first tile.
//   Then stream the hextile bytes of one rectangle on in_valid_i/data_byte_i;
//   a word is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Each byte gives at most one result word: a fill command (fill_valid_o)
//   and/or rect_done_o on the byte that finishes the last tile. Bytes that
//   give nothing produce no output word. Bytes after done are dropped.
// Timing:
//   One byte per clock sustained while out_stall_i is low. A byte is held in
//   the input register, decoded between the input register and the result
//   register, and its word is loaded into the result register behind out_valid_o.
//   When out_stall_i holds the result register full, the input register
//   fills and in_stall_o rises; both sides resume with no word lost.
// Reset:
//   rst_ni clears the rectangle registers, colors and parser to zero,
//   ready for a subencoding byte.
module hextile_rect_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        fill_valid_o,
  output logic [15:0] fill_x_o,
  output logic [15:0] fill_y_o,
  output logic [4:0]  fill_w_o,
  output logic [4:0]  fill_h_o,
  output logic [31:0] fill_color_o,
  output logic        rect_done_o
);

  hxt_pkg::hxt_cfg_wr_t cfg;
  hxt_pkg::hxt_result_t res;
  hxt_pkg::hxt_result_t out_res;
  logic                 go;
  logic [7:0]           byte_q;
  logic                 out_free;
  logic                 res_valid;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.wdata = cfg_wdata_i;

  hxt_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_free_i  (out_free),
    .go_o        (go),
    .byte_o      (byte_q)
  );

  hxt_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .go_i        (go),
    .byte_i      (byte_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  hxt_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go && res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign fill_valid_o = out_res.fill_valid;
  assign fill_x_o     = out_res.fill_x;
  assign fill_y_o     = out_res.fill_y;
  assign fill_w_o     = out_res.fill_w;
  assign fill_h_o     = out_res.fill_h;
  assign fill_color_o = out_res.fill_color;
  assign rect_done_o  = out_res.rect_done;

endmodule

[rtl/hxt_in_stage.sv]
`timescale 1ns / 1ps
// Input register of the hextile decoder: holds one stream byte for the parser.
// No dependencies; takes nothing from hxt_pkg.
module hxt_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       out_free_i,
  output logic       go_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // Held word moves on whenever the result register can take its outcome
  assign go_o       = valid_q && out_free_i;
  assign in_stall_o = valid_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign byte_o     = byte_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (go_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
    end
  end

endmodule

[rtl/hxt_parser.sv]
`timescale 1ns / 1ps
// Hextile parser: rectangle registers, tile walk and per-byte decode.
// Depends on hxt_pkg for phase codes, register indexes and result struct.
module hxt_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hxt_pkg::hxt_cfg_wr_t cfg_i,
  input  logic                go_i,
  input  logic [7:0]          byte_i,
  output hxt_pkg::hxt_result_t res_o,
  output logic                res_valid_o
);

  localparam int unsigned CW = hxt_pkg::CoordW;
  localparam int unsigned DW = hxt_pkg::DimW;

  // Rectangle registers
  logic [CW-1:0] rect_left_q, rect_left_d;
  logic [CW-1:0] rect_top_q, rect_top_d;
  logic [CW-1:0] rect_width_q, rect_width_d;
  logic [CW-1:0] rect_height_q, rect_height_d;

  // Parser state
  logic [hxt_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [CW-1:0]               tile_left_q, tile_left_d;
  logic [CW-1:0]               tile_top_q, tile_top_d;
  logic [CW-1:0]               off_x_q, off_x_d;
  logic [CW-1:0]               off_y_q, off_y_d;
  logic [DW-1:0]               tile_cols_q, tile_cols_d;
  logic [DW-1:0]               tile_rows_q, tile_rows_d;
  logic [4:0]                  flags_q, flags_d;
  logic [31:0]                 back_q, back_d;
  logic [31:0]                 fore_q, fore_d;
  logic [31:0]                 gather_q, gather_d;
  logic [1:0]                  bidx_q, bidx_d;
  logic [7:0]                  nsub_q, nsub_d;
  logic [hxt_pkg::RawCntW-1:0] raw_cnt_q, raw_cnt_d;
  logic [7:0]                  pos_q, pos_d;
  logic [3:0]                  raw_col_q, raw_col_d;
  logic [3:0]                  raw_row_q, raw_row_d;

  // Combinational helpers
  logic [31:0]               pix;
  logic                      pix_done;
  logic [4:0]                flags_new;
  logic [2*DW-1:0]           tile_area;
  logic [CW:0]               nx_off, ny_off;
  logic                      adv;
  logic                      cfg_hit;
  logic [7:0]                nsub_dec;
  logic [hxt_pkg::RawCntW-1:0] raw_dec;
  hxt_pkg::hxt_result_t      res;

  // Pixel assembly, least significant byte first
  assign pix      = gather_q | ({24'd0, byte_i} << {bidx_q, 3'b000});
  assign pix_done = (bidx_q == 2'd3);

  assign flags_new = byte_i[4:0];
  assign tile_area = {{DW{1'b0}}, tile_cols_q} * {{DW{1'b0}}, tile_rows_q};
  assign nx_off    = {1'b0, off_x_q} + (CW+1)'(hxt_pkg::TileSize);
  assign ny_off    = {1'b0, off_y_q} + (CW+1)'(hxt_pkg::TileSize);
  assign nsub_dec  = nsub_q - 8'd1;
  assign raw_dec   = raw_cnt_q - hxt_pkg::RawCntW'(1);

  // Register write decode
  always_comb begin
    rect_left_d   = rect_left_q;
    rect_top_d    = rect_top_q;
    rect_width_d  = rect_width_q;
    rect_height_d = rect_height_q;
    cfg_hit       = 1'b0;
    if (cfg_i.we) begin
      case (cfg_i.index)
        hxt_pkg::REG_RECT_LEFT: begin
          rect_left_d = cfg_i.wdata;
          cfg_hit     = 1'b1;
        end
        hxt_pkg::REG_RECT_TOP: begin
          rect_top_d = cfg_i.wdata;
          cfg_hit    = 1'b1;
        end
        hxt_pkg::REG_RECT_WIDTH: begin
          rect_width_d = cfg_i.wdata;
          cfg_hit      = 1'b1;
        end
        hxt_pkg::REG_RECT_HEIGHT: begin
          rect_height_d = cfg_i.wdata;
          cfg_hit       = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Per-byte decode
  always_comb begin
    phase_d     = phase_q;
    tile_left_d = tile_left_q;
    tile_top_d  = tile_top_q;
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    tile_cols_d = tile_cols_q;
    tile_rows_d = tile_rows_q;
    flags_d     = flags_q;
    back_d      = back_q;
    fore_d      = fore_q;
    gather_d    = gather_q;
    bidx_d      = bidx_q;
    nsub_d      = nsub_q;
    raw_cnt_d   = raw_cnt_q;
    pos_d       = pos_q;
    raw_col_d   = raw_col_q;
    raw_row_d   = raw_row_q;
    res         = '0;
    adv         = 1'b0;

    if (go_i) begin
      case (phase_q)
        hxt_pkg::PH_SUBENC: begin
          flags_d  = flags_new;
          gather_d = '0;
          bidx_d   = '0;
          if (flags_new[hxt_pkg::SE_RAW_BIT]) begin
            raw_cnt_d = tile_area[hxt_pkg::RawCntW-1:0];
            raw_col_d = '0;
            raw_row_d = '0;
            if (tile_area != '0) begin
              phase_d = hxt_pkg::PH_RAW;
            end else begin
              adv = 1'b1;
            end
          end else if (flags_new[hxt_pkg::SE_BG_BIT]) begin
            phase_d = hxt_pkg::PH_BG;
          end else begin
            // kept background covers the whole tile
            res.fill_valid = 1'b1;
            res.fill_x     = tile_left_q;
            res.fill_y     = tile_top_q;
            res.fill_w     = tile_cols_q;
            res.fill_h     = tile_rows_q;
            res.fill_color = back_q;
            if (flags_new[hxt_pkg::SE_FG_BIT]) begin
              phase_d = hxt_pkg::PH_FG;
            end else if (flags_new[hxt_pkg::SE_ANY_BIT]) begin
              phase_d = hxt_pkg::PH_NSUB;
            end else begin
              adv = 1'b1;
            end
          end
        end
        hxt_pkg::PH_BG: begin
          gather_d = pix;
          bidx_d   = bidx_q + 2'd1;
          if (pix_done) begin
            gather_d       = '0;
            back_d         = pix;
            res.fill_valid = 1'b1;
            res.fill_x     = tile_left_q;
            res.fill_y     = tile_top_q;
            res.fill_w     = tile_cols_q;
            res.fill_h     = tile_rows_q;
            res.fill_color = pix;
            if (flags_q[hxt_pkg::SE_FG_BIT]) begin
              phase_d = hxt_pkg::PH_FG;
            end else if (flags_q[hxt_pkg::SE_ANY_BIT]) begin
              phase_d = hxt_pkg::PH_NSUB;
            end else begin
              adv = 1'b1;
            end
          end
        end
        hxt_pkg::PH_FG: begin
          gather_d = pix;
          bidx_d   = bidx_q + 2'd1;
          if (pix_done) begin
            gather_d = '0;
            fore_d   = pix;
            if (flags_q[hxt_pkg::SE_ANY_BIT]) begin
              phase_d = hxt_pkg::PH_NSUB;
            end else begin
              adv = 1'b1;
            end
          end
        end
        hxt_pkg::PH_NSUB: begin
          nsub_d = byte_i;
          if (byte_i == 8'd0) begin
            adv = 1'b1;
          end else if (flags_q[hxt_pkg::SE_COL_BIT]) begin
            phase_d = hxt_pkg::PH_SUBCOL;
          end else begin
            phase_d = hxt_pkg::PH_SUBPOS;
          end
        end
        hxt_pkg::PH_SUBCOL: begin
          gather_d = pix;
          bidx_d   = bidx_q + 2'd1;
          if (pix_done) begin
            gather_d = '0;
            fore_d   = pix;
            phase_d  = hxt_pkg::PH_SUBPOS;
          end
        end
        hxt_pkg::PH_SUBPOS: begin
          pos_d   = byte_i;
          phase_d = hxt_pkg::PH_SUBDIM;
        end
        hxt_pkg::PH_SUBDIM: begin
          // subrectangle is not clipped to the tile
          res.fill_valid = 1'b1;
          res.fill_x     = tile_left_q + {12'd0, pos_q[7:4]};
          res.fill_y     = tile_top_q + {12'd0, pos_q[3:0]};
          res.fill_w     = {1'b0, byte_i[7:4]} + 5'd1;
          res.fill_h     = {1'b0, byte_i[3:0]} + 5'd1;
          res.fill_color = fore_q;
          nsub_d         = nsub_dec;
          if (nsub_dec == 8'd0) begin
            adv = 1'b1;
          end else if (flags_q[hxt_pkg::SE_COL_BIT]) begin
            phase_d = hxt_pkg::PH_SUBCOL;
          end else begin
            phase_d = hxt_pkg::PH_SUBPOS;
          end
        end
        hxt_pkg::PH_RAW: begin
          gather_d = pix;
          bidx_d   = bidx_q + 2'd1;
          if (pix_done) begin
            gather_d       = '0;
            res.fill_valid = 1'b1;
            res.fill_x     = tile_left_q + {12'd0, raw_col_q};
            res.fill_y     = tile_top_q + {12'd0, raw_row_q};
            res.fill_w     = 5'd1;
            res.fill_h     = 5'd1;
            res.fill_color = pix;
            raw_cnt_d      = raw_dec;
            // row-major walk within the clipped tile
            if (({1'b0, raw_col_q} + 5'd1) == tile_cols_q) begin
              raw_col_d = '0;
              raw_row_d = raw_row_q + 4'd1;
            end else begin
              raw_col_d = raw_col_q + 4'd1;
            end
            if (raw_dec == '0) begin
              adv = 1'b1;
            end
          end
        end
        default: begin
          phase_d = hxt_pkg::PH_DONE;
        end
      endcase
    end

    // Step to the next tile, or finish the rectangle
    if (adv) begin
      if (nx_off < {1'b0, rect_width_q}) begin
        off_x_d     = nx_off[CW-1:0];
        tile_left_d = rect_left_q + nx_off[CW-1:0];
        tile_cols_d = hxt_pkg::clip_len(rect_width_q, nx_off[CW-1:0]);
        phase_d     = hxt_pkg::PH_SUBENC;
      end else if (ny_off < {1'b0, rect_height_q}) begin
        off_x_d     = '0;
        tile_left_d = rect_left_q;
        tile_cols_d = hxt_pkg::clip_len(rect_width_q, '0);
        off_y_d     = ny_off[CW-1:0];
        tile_top_d  = rect_top_q + ny_off[CW-1:0];
        tile_rows_d = hxt_pkg::clip_len(rect_height_q, ny_off[CW-1:0]);
        phase_d     = hxt_pkg::PH_SUBENC;
      end else begin
        phase_d       = hxt_pkg::PH_DONE;
        res.rect_done = 1'b1;
      end
    end

    // Register write re-arms at the first tile; colors are kept
    if (cfg_hit) begin
      phase_d     = hxt_pkg::PH_SUBENC;
      tile_left_d = rect_left_d;
      tile_top_d  = rect_top_d;
      off_x_d     = '0;
      off_y_d     = '0;
      tile_cols_d = hxt_pkg::clip_len(rect_width_d, '0);
      tile_rows_d = hxt_pkg::clip_len(rect_height_d, '0);
      flags_d     = '0;
      gather_d    = '0;
      bidx_d      = '0;
      nsub_d      = '0;
      raw_cnt_d   = '0;
      pos_d       = '0;
      raw_col_d   = '0;
      raw_row_d   = '0;
    end
  end

  assign res_o       = res;
  assign res_valid_o = res.fill_valid || res.rect_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= '0;
      rect_top_q    <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
      phase_q       <= hxt_pkg::PH_SUBENC;
      tile_left_q   <= '0;
      tile_top_q    <= '0;
      off_x_q       <= '0;
      off_y_q       <= '0;
      tile_cols_q   <= '0;
      tile_rows_q   <= '0;
      flags_q       <= '0;
      back_q        <= '0;
      fore_q        <= '0;
      gather_q      <= '0;
      bidx_q        <= '0;
      nsub_q        <= '0;
      raw_cnt_q     <= '0;
      pos_q         <= '0;
      raw_col_q     <= '0;
      raw_row_q     <= '0;
    end else begin
      rect_left_q   <= rect_left_d;
      rect_top_q    <= rect_top_d;
      rect_width_q  <= rect_width_d;
      rect_height_q <= rect_height_d;
      phase_q       <= phase_d;
      tile_left_q   <= tile_left_d;
      tile_top_q    <= tile_top_d;
      off_x_q       <= off_x_d;
      off_y_q       <= off_y_d;
      tile_cols_q   <= tile_cols_d;
      tile_rows_q   <= tile_rows_d;
      flags_q       <= flags_d;
      back_q        <= back_d;
      fore_q        <= fore_d;
      gather_q      <= gather_d;
      bidx_q        <= bidx_d;
      nsub_q        <= nsub_d;
      raw_cnt_q     <= raw_cnt_d;
      pos_q         <= pos_d;
      raw_col_q     <= raw_col_d;
      raw_row_q     <= raw_row_d;
    end
  end

endmodule

[rtl/hxt_out_stage.sv]
`timescale 1ns / 1ps
// Result register of the hextile decoder with valid/stall output handshake.
// Depends on hxt_pkg for the result struct.
module hxt_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  hxt_pkg::hxt_result_t res_i,
  output logic                 out_free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hxt_pkg::hxt_result_t res_o
);

  logic                 valid_q, valid_d;
  hxt_pkg::hxt_result_t res_q;

  // Register can take a new word when empty or when its word leaves now
  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[rtl/hxt_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the hextile rectangle decoder, bound to the top level.
// Depends on hextile_rect_decoder port names only.
module hxt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        fill_valid_o,
  input logic [15:0] fill_x_o,
  input logic [15:0] fill_y_o,
  input logic [4:0]  fill_w_o,
  input logic [4:0]  fill_h_o,
  input logic [31:0] fill_color_o,
  input logic        rect_done_o
);

  // A stalled input word stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i))
    else $error("input word changed while stalled");

  // A stalled output word keeps its x, y, color and done mark
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fill_x_o) &&
      $stable(fill_y_o) && $stable(fill_color_o) && $stable(rect_done_o))
    else $error("output word changed while stalled");

  // Every word carries a fill or the done mark
  a_word_meaning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_valid_o || rect_done_o)
    else $error("empty output word");

  // Without a fill the fill fields are zero
  a_no_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fill_valid_o |-> fill_x_o == 16'd0 && fill_y_o == 16'd0 &&
      fill_w_o == 5'd0 && fill_h_o == 5'd0 && fill_color_o == 32'd0)
    else $error("fill fields set without fill");

  // Fill size never exceeds a tile
  a_fill_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_valid_o |-> fill_w_o <= 5'd16 && fill_h_o <= 5'd16)
    else $error("fill larger than a tile");

endmodule

bind hextile_rect_decoder hxt_checker u_hxt_checker (.*);
